>>> design/pcam_pkg.sv
// shared types, constants and register codes for the per-pixel class argmax core
package pcam_pkg;

   localparam int SCORE_W     = 16;
   localparam int CLASS_W     = 8;
   localparam int PIXIDX_W    = 16;
   localparam int ENTRY_W     = SCORE_W + CLASS_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;
   localparam int LAYOUT_W    = 2;
   localparam int CLASSES_W   = 9;
   localparam int PIXELS_W    = 17;
   localparam int OUTQ_DEPTH  = 3;
   localparam int OUTQ_PTR_W  = 2;
   localparam int OUTQ_CNT_W  = 2;

   localparam int DEF_MAX_PIXELS  = 65536;
   localparam int DEF_MAX_CLASSES = 256;

   localparam logic [CLASSES_W-1:0] CLASS_COUNT_RESET      = 9'd1;
   localparam logic [PIXELS_W-1:0]  PIXELS_PER_FRAME_RESET = 17'd65536;

   typedef enum logic [LAYOUT_W-1:0] {
      LAYOUT_PLANAR      = 2'd0,
      LAYOUT_INTERLEAVED = 2'd1,
      LAYOUT_PREARGMAX   = 2'd2
   } layout_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LAYOUT_MODE      = 2'd0,
      CSR_CLASS_COUNT      = 2'd1,
      CSR_PIXELS_PER_FRAME = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PIXIDX_W-1:0] pixel_index;
      logic [CLASS_W-1:0]  class_index;
      logic                frame_last;
   } result_type;

   // clamp a pre-argmaxed id into the class range
   function automatic logic [CLASS_W-1:0] clamp_class(input logic signed [SCORE_W-1:0] s);
      logic [CLASS_W-1:0] c;
      if (s < 0) begin
         c = '0;
      end else if (s > 16'sd255) begin
         c = '1;
      end else begin
         c = s[CLASS_W-1:0];
      end
      return c;
   endfunction

endpackage

>>> design/pcam_ram.sv
// generic single-write, single-read memory with registered read data
module pcam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/per_pixel_class_argmax_core.sv
// per-pixel class argmax: interleaved, planar and pre-argmaxed score layouts
// the item completing a result passes the compare stage register, then the queue driving rsp_
// throughput: 1 item per cycle unless stalled, set by one best-store read and write per cycle
//   (read-modify-write over 2 stages, a one-entry forward covers back-to-back hits)
// a 3-entry result queue lets items keep flowing while a result waits to be taken
// reset: synchronous, restores register defaults, clears counters and queue; the store is not cleared
module per_pixel_class_argmax_core #(
   parameter int MAX_PIXELS  = pcam_pkg::DEF_MAX_PIXELS,
   parameter int MAX_CLASSES = pcam_pkg::DEF_MAX_CLASSES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pcam_pkg::SCORE_W-1:0]    req_score,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pcam_pkg::PIXIDX_W-1:0]          rsp_pixel_index,
   output logic [pcam_pkg::CLASS_W-1:0]           rsp_class_index,
   output logic                                   rsp_frame_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pcam_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pcam_pkg::CSR_DATA_W-1:0]        csr_data
);
   import pcam_pkg::*;

   localparam int PIX_AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CH_W   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int NPW    = $clog2(MAX_PIXELS + 1);
   localparam int CMPW   = (NPW > PIXELS_W) ? NPW : PIXELS_W;

   // configuration registers
   logic [LAYOUT_W-1:0]  layout_mode_ff;
   logic [CLASSES_W-1:0] class_count_ff;
   logic [PIXELS_W-1:0]  pixels_per_frame_ff;
   logic                 csr_write;

   // stream counters
   logic [CH_W-1:0]   channel_ff, channel_in;
   logic [PIX_AW-1:0] pixel_ff, pixel_in;

   // compare stage
   logic                     s1_valid_ff;
   layout_type               s1_mode_ff;
   logic                     s1_first_ff;
   logic [CH_W-1:0]          s1_channel_ff;
   logic [PIX_AW-1:0]        s1_pixel_ff;
   logic                     s1_emit_ff;
   logic                     s1_last_ff;
   logic signed [SCORE_W-1:0] s1_score_ff;

   // interleaved running best
   logic signed [SCORE_W-1:0] best_score_ff;
   logic [CLASS_W-1:0]        best_class_ff;

   // write-to-read forward for the store
   logic                fwd_valid_ff;
   logic [PIX_AW-1:0]   fwd_addr_ff;
   logic [ENTRY_W-1:0]  fwd_data_ff;

   // result queue
   result_type             outq_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]  head_ff, tail_ff;
   logic [OUTQ_CNT_W-1:0]  count_ff;

   logic                     accept;
   layout_type               mode;
   logic [CLASSES_W-1:0]     eff_classes;
   logic [CMPW-1:0]          eff_pixels;
   logic                     ch_last;
   logic                     pix_wrap;
   logic                     emit;
   logic [CH_W-1:0]          ch_inc;
   logic [PIX_AW-1:0]        pix_inc;

   logic [ENTRY_W-1:0]       rd_data;
   logic [ENTRY_W-1:0]       old_entry;
   logic signed [SCORE_W-1:0] old_score;
   logic                     take;
   logic [CLASS_W-1:0]       s1_class;
   logic [ENTRY_W-1:0]       new_entry;
   logic                     st_we;
   logic [CLASS_W-1:0]       result_class;
   logic                     push, pop;
   result_type               push_item;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = (3'(count_ff) + 3'(s1_valid_ff)) >= 3'(OUTQ_DEPTH);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_mode_ff      <= LAYOUT_INTERLEAVED;
         class_count_ff      <= CLASS_COUNT_RESET;
         pixels_per_frame_ff <= PIXELS_PER_FRAME_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LAYOUT_MODE:      layout_mode_ff      <= csr_data[LAYOUT_W-1:0];
            CSR_CLASS_COUNT:      class_count_ff      <= csr_data[CLASSES_W-1:0];
            CSR_PIXELS_PER_FRAME: pixels_per_frame_ff <= csr_data[PIXELS_W-1:0];
            default: ;
         endcase
      end
   end

   // effective counts; unused layout code runs as pre-argmaxed
   always_comb begin
      case (layout_mode_ff)
         LAYOUT_PLANAR:      mode = LAYOUT_PLANAR;
         LAYOUT_INTERLEAVED: mode = LAYOUT_INTERLEAVED;
         default:            mode = LAYOUT_PREARGMAX;
      endcase
      if (class_count_ff == '0) begin
         eff_classes = CLASSES_W'(1);
      end else if (class_count_ff > CLASSES_W'(MAX_CLASSES)) begin
         eff_classes = CLASSES_W'(MAX_CLASSES);
      end else begin
         eff_classes = class_count_ff;
      end
      if (pixels_per_frame_ff == '0) begin
         eff_pixels = CMPW'(1);
      end else if (CMPW'(pixels_per_frame_ff) > CMPW'(MAX_PIXELS)) begin
         eff_pixels = CMPW'(MAX_PIXELS);
      end else begin
         eff_pixels = CMPW'(pixels_per_frame_ff);
      end
   end

   always_comb begin
      ch_inc   = channel_ff + CH_W'(1);
      pix_inc  = pixel_ff + PIX_AW'(1);
      ch_last  = (CLASSES_W'(channel_ff) + CLASSES_W'(1)) >= eff_classes;
      pix_wrap = (CMPW'(pixel_ff) + CMPW'(1)) >= eff_pixels;
      channel_in = channel_ff;
      pixel_in   = pixel_ff;
      emit       = 1'b0;
      case (mode)
         LAYOUT_PLANAR: begin
            emit     = ch_last;
            pixel_in = pix_wrap ? '0 : pix_inc;
            if (pix_wrap) begin
               channel_in = ch_last ? '0 : ch_inc;
            end
         end
         LAYOUT_INTERLEAVED: begin
            emit = ch_last;
            if (ch_last) begin
               channel_in = '0;
               pixel_in   = pix_wrap ? '0 : pix_inc;
            end else begin
               channel_in = ch_inc;
            end
         end
         default: begin
            emit     = 1'b1;
            pixel_in = pix_wrap ? '0 : pix_inc;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         channel_ff <= '0;
         pixel_ff   <= '0;
      end else if (accept) begin
         channel_ff <= channel_in;
         pixel_ff   <= pixel_in;
      end
   end

   // compare stage never holds; the queue credit in req_stall guarantees room
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff    <= mode;
         s1_first_ff   <= (channel_ff == '0);
         s1_channel_ff <= channel_ff;
         s1_pixel_ff   <= pixel_ff;
         s1_emit_ff    <= emit;
         s1_last_ff    <= pix_wrap;
         s1_score_ff   <= req_score;
      end
   end

   pcam_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PIXELS),
      .AW    (PIX_AW)
   ) u_best_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (s1_pixel_ff),
      .wr_data (new_entry),
      .rd_addr (pixel_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      // the read of this entry raced the write of the item just ahead
      old_entry = (fwd_valid_ff && (fwd_addr_ff == s1_pixel_ff)) ? fwd_data_ff : rd_data;
      old_score = signed'(old_entry[ENTRY_W-1:CLASS_W]);
      s1_class  = CLASS_W'(s1_channel_ff);
      st_we     = s1_valid_ff && (s1_mode_ff == LAYOUT_PLANAR);
      take      = 1'b0;
      new_entry = old_entry;
      case (s1_mode_ff)
         LAYOUT_PLANAR: begin
            take         = s1_first_ff || (s1_score_ff > old_score);
            new_entry    = take ? {s1_score_ff, s1_class} : old_entry;
            result_class = new_entry[CLASS_W-1:0];
         end
         LAYOUT_INTERLEAVED: begin
            take         = s1_first_ff || (s1_score_ff > best_score_ff);
            result_class = take ? s1_class : best_class_ff;
         end
         default: begin
            result_class = clamp_class(s1_score_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= '0;
         best_class_ff <= '0;
      end else if (s1_valid_ff && (s1_mode_ff == LAYOUT_INTERLEAVED) && take) begin
         best_score_ff <= s1_score_ff;
         best_class_ff <= s1_class;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= st_we;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         fwd_addr_ff <= s1_pixel_ff;
         fwd_data_ff <= new_entry;
      end
   end

   // result queue
   assign push = s1_valid_ff && s1_emit_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      push_item.pixel_index = PIXIDX_W'(s1_pixel_ff);
      push_item.class_index = result_class;
      push_item.frame_last  = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= (tail_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : tail_ff + OUTQ_PTR_W'(1);
         end
         if (pop) begin
            head_ff <= (head_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : head_ff + OUTQ_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + OUTQ_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - OUTQ_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         outq_ff[tail_ff] <= push_item;
      end
   end

   assign rsp_valid       = (count_ff != '0);
   assign rsp_pixel_index = outq_ff[head_ff].pixel_index;
   assign rsp_class_index = outq_ff[head_ff].class_index;
   assign rsp_frame_last  = outq_ff[head_ff].frame_last;

endmodule

>>> design/pcam_checker.sv
// port-level checks for the per-pixel class argmax core, bound to the top level
module pcam_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [pcam_pkg::PIXIDX_W-1:0]       rsp_pixel_index,
   input  logic [pcam_pkg::CLASS_W-1:0]        rsp_class_index,
   input  logic                                rsp_frame_last,
   input  logic                                csr_valid,
   input  logic                                csr_ready
);
   import pcam_pkg::*;

   logic                req_acc, rsp_acc;
   logic [PIXIDX_W-1:0] exp_pix_ff;
   logic [31:0]         pending_ff;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // expected pixel index of the next result; a register write restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_pix_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         exp_pix_ff <= '0;
      end else if (rsp_acc) begin
         exp_pix_ff <= rsp_frame_last ? '0 : rsp_pixel_index + PIXIDX_W'(1);
      end
   end

   // items taken that have not yet produced a result, as an upper bound
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_acc && !rsp_acc) begin
         pending_ff <= pending_ff + 32'd1;
      end else if (rsp_acc && !req_acc) begin
         pending_ff <= pending_ff - 32'd1;
      end
   end

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_index)
         && $stable(rsp_class_index) && $stable(rsp_frame_last))
      else $error("stalled result changed");

   a_pixel_order: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> rsp_pixel_index == exp_pix_ff)
      else $error("result pixel index out of order");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> (pending_ff != '0) || req_acc)
      else $error("result delivered without a matching item");

endmodule

bind per_pixel_class_argmax_core pcam_checker u_pcam_checker (.*);

>>> bench/tb_per_pixel_class_argmax_core.sv
// self-checking testbench for the per-pixel class argmax core
module tb_per_pixel_class_argmax_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pcam_pkg::*;

   localparam int IDLE_PCT       = 23;
   localparam int DRAIN_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1650;
   localparam int HOLD_CYCLES    = 60;
   localparam int STEADY_FROM    = 700;
   localparam int STEADY_TO      = 1000;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED    = 2'd3;
   localparam logic [LAYOUT_W-1:0]    LAYOUT_UNUSED = 2'd3;

   class pixel_class_scoreboard;
      logic [LAYOUT_W-1:0]       layout_reg;
      logic [CLASSES_W-1:0]      classes_reg;
      logic [PIXELS_W-1:0]       pixels_reg;
      int                        channel_cnt;
      int                        pixel_cnt;
      logic signed [SCORE_W-1:0] best_score;
      logic [CLASS_W-1:0]        best_class;
      logic signed [SCORE_W-1:0] plane_score [DEF_MAX_PIXELS];
      logic [CLASS_W-1:0]        plane_class [DEF_MAX_PIXELS];
      result_type                expected_pixels[$];
      int                        mismatches;

      function new();
         layout_reg  = LAYOUT_INTERLEAVED;
         classes_reg = CLASS_COUNT_RESET;
         pixels_reg  = PIXELS_PER_FRAME_RESET;
         channel_cnt = 0;
         pixel_cnt   = 0;
         best_score  = '0;
         best_class  = '0;
         mismatches  = 0;
      endfunction

      static function int fit_classes(int v);
         if (v == 0) return 1;
         if (v > DEF_MAX_CLASSES) return DEF_MAX_CLASSES;
         return v;
      endfunction

      static function int fit_pixels(int v);
         if (v == 0) return 1;
         if (v > DEF_MAX_PIXELS) return DEF_MAX_PIXELS;
         return v;
      endfunction

      // any write, even to the unused index, restarts the frame
      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LAYOUT_MODE:      layout_reg = data[LAYOUT_W-1:0];
            CSR_CLASS_COUNT:      classes_reg = data[CLASSES_W-1:0];
            CSR_PIXELS_PER_FRAME: pixels_reg = data[PIXELS_W-1:0];
            default: ;
         endcase
         channel_cnt = 0;
         pixel_cnt   = 0;
      endfunction

      function bit next_pixel();
         if (pixel_cnt + 1 >= fit_pixels(pixels_reg)) begin
            pixel_cnt = 0;
            return 1'b1;
         end
         pixel_cnt++;
         return 1'b0;
      endfunction

      function void expect_pixel(int pix, logic [CLASS_W-1:0] cls, bit last);
         result_type r;
         r.pixel_index = pix[PIXIDX_W-1:0];
         r.class_index = cls;
         r.frame_last  = last;
         expected_pixels.push_back(r);
      endfunction

      function void note_score(logic signed [SCORE_W-1:0] s);
         int                 nc;
         int                 pix;
         int                 ch;
         logic [CLASS_W-1:0] cls;
         bit                 last;
         nc  = fit_classes(classes_reg);
         pix = pixel_cnt;
         ch  = channel_cnt;
         if (layout_reg >= LAYOUT_PREARGMAX) begin
            if (s < 0) begin
               cls = '0;
            end else if (s > 255) begin
               cls = '1;
            end else begin
               cls = s[CLASS_W-1:0];
            end
            last = next_pixel();
            expect_pixel(pix, cls, last);
         end else if (layout_reg == LAYOUT_INTERLEAVED) begin
            if (ch == 0 || s > best_score) begin
               best_score = s;
               best_class = ch[CLASS_W-1:0];
            end
            if (ch + 1 >= nc) begin
               channel_cnt = 0;
               last = next_pixel();
               expect_pixel(pix, best_class, last);
            end else begin
               channel_cnt = ch + 1;
            end
         end else begin
            // planar: plane 0 seeds the entry, later planes compare against it
            if (ch == 0 || s > plane_score[pix]) begin
               plane_score[pix] = s;
               plane_class[pix] = ch[CLASS_W-1:0];
            end
            cls  = plane_class[pix];
            last = next_pixel();
            if (ch + 1 >= nc) begin
               if (last) channel_cnt = 0;
               expect_pixel(pix, cls, last);
            end else if (last) begin
               channel_cnt = ch + 1;
            end
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_pixel(logic [PIXIDX_W-1:0] pix, logic [CLASS_W-1:0] cls, logic last);
         result_type e;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected result pixel %0d class %0d", pix, cls));
            return;
         end
         e = expected_pixels.pop_front();
         if (pix !== e.pixel_index)
            report_mismatch($sformatf("pixel_index %0d, want %0d", pix, e.pixel_index));
         if (cls !== e.class_index)
            report_mismatch($sformatf("class_index %0d, want %0d (pixel %0d)",
                                      cls, e.class_index, e.pixel_index));
         if (last !== e.frame_last)
            report_mismatch($sformatf("frame_last %0b, want %0b (pixel %0d)",
                                      last, e.frame_last, e.pixel_index));
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SCORE_W-1:0]  req_score = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [PIXIDX_W-1:0]        rsp_pixel_index;
   logic [CLASS_W-1:0]         rsp_class_index;
   logic                       rsp_frame_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   pixel_class_scoreboard sb = new();

   int  items_sent  = 0;
   bit  steady      = 1'b0;
   int  hold_asks   = 0;
   int  hold_served = 0;
   int  hold_left   = 0;
   int  stuck       = 0;

   per_pixel_class_argmax_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_score       (req_score),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_class_index (rsp_class_index),
      .rsp_frame_last  (rsp_frame_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && !req_stall) sb.note_score(req_score);
         if (rsp_valid && !rsp_stall) sb.check_pixel(rsp_pixel_index, rsp_class_index,
                                                     rsp_frame_last);
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_asks != hold_served) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         stuck = 0;
      else
         stuck++;
      if (stuck >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic signed [SCORE_W-1:0] pick_score(logic [LAYOUT_W-1:0] lay);
      int k;
      k = $urandom_range(0, 9);
      if (lay >= LAYOUT_PREARGMAX) begin
         if (k < 7) return SCORE_W'($urandom_range(0, 255));
         return SCORE_W'($urandom);
      end
      case (k)
         5, 6:    return SCORE_W'($urandom_range(0, 4) - 2);  // near ties
         7:       return 16'sh8000;
         8:       return 16'sh7fff;
         default: return SCORE_W'($urandom);
      endcase
   endfunction

   task send_score(logic signed [SCORE_W-1:0] s);
      steady = (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
      while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_score <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task stream_scores(int n, logic [LAYOUT_W-1:0] lay);
      int i;
      for (i = 0; i < n; i++) send_score(pick_score(lay));
      req_valid <= 1'b0;
   endtask

   task wait_idle();
      @(posedge clock);
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task configure(logic [LAYOUT_W-1:0] lay, int cc, int px);
      logic [CSR_DATA_W-1:0] vals [3];
      int                    first;
      int                    k;
      wait_idle();
      vals[CSR_LAYOUT_MODE]      = CSR_DATA_W'(lay);
      vals[CSR_CLASS_COUNT]      = CSR_DATA_W'(cc);
      vals[CSR_PIXELS_PER_FRAME] = CSR_DATA_W'(px);
      first = $urandom_range(0, 2);
      for (k = 0; k < 3; k++) write_csr(CSR_INDEX_W'((first + k) % 3), vals[(first + k) % 3]);
      if ($urandom_range(0, 99) < 20) write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // a write to the unused index only restarts the frame
   task restart_frame();
      wait_idle();
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [LAYOUT_W-1:0] lay;
      int                  cc;
      int                  px;
      int                  ec;
      int                  ep;
      int                  per_frame;
      int                  n;
      int                  k;
      int                  start;

      wait (!reset);
      @(posedge clock);

      // register defaults: interleaved, one class, full frame
      send_score(16'sh8000);
      send_score(16'sh7fff);
      send_score(16'sh0000);
      send_score(16'shffff);
      req_valid <= 1'b0;

      // pre-argmaxed ids, clamped both ways
      configure(LAYOUT_PREARGMAX, 5, 3);
      send_score(16'sh8000);
      send_score(16'shffff);
      send_score(16'sh0000);
      send_score(16'sd255);
      send_score(16'sd256);
      send_score(16'sh7fff);
      req_valid <= 1'b0;

      // unused layout code, zero classes and zero pixels
      configure(LAYOUT_UNUSED, 0, 0);
      send_score(16'sd77);
      send_score(16'sd1000);
      req_valid <= 1'b0;

      // interleaved ties keep the lowest class
      configure(LAYOUT_INTERLEAVED, 3, 2);
      send_score(16'sd4);
      send_score(16'sd4);
      send_score(16'sd4);
      send_score(-16'sd5);
      send_score(16'sd3);
      send_score(16'sd3);
      req_valid <= 1'b0;

      // planar, two planes of three pixels
      configure(LAYOUT_PLANAR, 2, 3);
      send_score(16'sd10);
      send_score(-16'sd7);
      send_score(16'sd0);
      send_score(16'sd10);
      send_score(-16'sd6);
      send_score(16'sd1);
      req_valid <= 1'b0;

      start = items_sent;

      // widest class count, top class wins
      configure(LAYOUT_INTERLEAVED, 256, 1);
      for (k = 0; k < 256; k++)
         send_score(k == 255 ? 16'sh7fff : {1'b1, 15'($urandom)});
      req_valid <= 1'b0;

      // class count above the limit, planar
      configure(LAYOUT_PLANAR, 511, 1);
      stream_scores(256, LAYOUT_PLANAR);

      // long receiver hold-off while items keep coming
      configure(LAYOUT_PREARGMAX, 0, 131071);
      hold_asks++;
      stream_scores(40, LAYOUT_PREARGMAX);

      while (items_sent - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: lay = LAYOUT_PLANAR;
            4, 5, 6, 7: lay = LAYOUT_INTERLEAVED;
            8:          lay = LAYOUT_PREARGMAX;
            default:    lay = LAYOUT_UNUSED;
         endcase
         if (lay >= LAYOUT_PREARGMAX) begin
            cc = $urandom_range(0, 511);
         end else begin
            case ($urandom_range(0, 9))
               0:       cc = 0;
               1:       cc = 1;
               2:       cc = $urandom_range(7, 12);
               default: cc = $urandom_range(2, 6);
            endcase
         end
         case ($urandom_range(0, 9))
            0:       px = 0;
            1:       px = ($urandom_range(0, 1) == 1) ? 131071 : $urandom_range(65, 131071);
            2:       px = DEF_MAX_PIXELS;
            default: px = (lay >= LAYOUT_PREARGMAX) ? $urandom_range(1, 20)
                                                    : $urandom_range(1, 6);
         endcase
         configure(lay, cc, px);

         ec = (lay >= LAYOUT_PREARGMAX) ? 1 : pixel_class_scoreboard::fit_classes(cc);
         ep = pixel_class_scoreboard::fit_pixels(px);
         per_frame = ec * ep;
         // huge frames never complete, so plane 0 is never read back
         if (ep > 64) n = $urandom_range(1, 40);
         else n = per_frame * $urandom_range(1, 3);
         if ($urandom_range(0, 99) < 15) n = $urandom_range(1, n);
         stream_scores(n, lay);

         if ($urandom_range(0, 99) < 15) begin
            restart_frame();
            stream_scores((ep > 64) ? $urandom_range(1, 40) : per_frame, lay);
         end
      end

      wait_idle();
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
design/pcam_pkg.sv
design/pcam_ram.sv
design/per_pixel_class_argmax_core.sv
design/pcam_checker.sv
bench/tb_per_pixel_class_argmax_core.sv
